// ===== design/kvdc_pkg.sv =====
// kvdc_pkg: sizes, types and command structs shared by the keyed distinct counter
// used by every module of the block; depends on nothing

package kvdc_pkg;

    localparam int KEY_ENTRIES   = 256;
    localparam int COLOR_ENTRIES = 256;

    localparam int LABEL_W = 32;
    localparam int COLOR_W = 32;
    localparam int OUT_W   = 9;
    localparam int OUT_MAX = (1 << OUT_W) - 1;

    localparam int KEY_CW = $clog2(KEY_ENTRIES + 1);
    localparam int COL_IW = $clog2(COLOR_ENTRIES);
    localparam int COL_CW = $clog2(COLOR_ENTRIES + 1);
    // a color can be held by every key at most
    localparam int CNT_W  = KEY_CW;

    // reduction trees gather GRP cells per group, then all groups
    localparam int GRP     = 16;
    localparam int KEY_NG  = (KEY_ENTRIES + GRP - 1) / GRP;
    localparam int COL_NG  = (COLOR_ENTRIES + GRP - 1) / GRP;
    localparam int KEY_PAD = KEY_NG * GRP;
    localparam int COL_PAD = COL_NG * GRP;

    typedef struct packed {
        logic               valid;
        logic [COLOR_W-1:0] value;
        logic [CNT_W-1:0]   count;
    } color_entry_t;

    typedef struct packed {
        logic               cmp;
        logic               hit_wr;
        logic               alloc;
        logic [KEY_CW-1:0]  fill;
        logic [LABEL_W-1:0] label;
        logic [COLOR_W-1:0] color;
    } key_cmd_t;

    typedef struct packed {
        logic               hit;
        logic [COLOR_W-1:0] prev_color;
    } key_res_t;

    typedef struct packed {
        logic               cmp;
        logic               dec;
        logic               shift;
        logic               inc;
        logic               alloc;
        logic [COL_CW-1:0]  fill;
        logic [COL_IW-1:0]  old_idx;
        logic [COLOR_W-1:0] new_color;
        logic [COLOR_W-1:0] prev_color;
    } color_cmd_t;

    typedef struct packed {
        logic              new_found;
        logic              old_one;
        logic [COL_IW-1:0] old_idx;
    } color_res_t;

endpackage

// ===== design/kvdc_key_cell.sv =====
// kvdc_key_cell: one entry of the key table (label, current color, match flag)
// depends on kvdc_pkg

module kvdc_key_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  kvdc_pkg::key_cmd_t            cmd,
    input  logic                          sel,
    output logic                          match,
    output logic [kvdc_pkg::COLOR_W-1:0]  color
);

    logic                          valid_reg;
    logic                          valid_next;
    logic                          match_reg;
    logic                          match_next;
    logic [kvdc_pkg::LABEL_W-1:0]  label_reg;
    logic [kvdc_pkg::LABEL_W-1:0]  label_next;
    logic [kvdc_pkg::COLOR_W-1:0]  color_reg;
    logic [kvdc_pkg::COLOR_W-1:0]  color_next;

    always_comb
    begin
        valid_next = valid_reg;
        match_next = match_reg;
        label_next = label_reg;
        color_next = color_reg;
        if (cmd.cmp)
        begin
            match_next = valid_reg && (label_reg == cmd.label);
        end
        if (cmd.hit_wr && match_reg)
        begin
            color_next = cmd.color;
        end
        else if (cmd.alloc && sel)
        begin
            valid_next = 1'b1;
            label_next = cmd.label;
            color_next = cmd.color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        label_reg <= label_next;
        color_reg <= color_next;
    end

    assign match = match_reg;
    assign color = color_reg;

endmodule

// ===== design/kvdc_color_cell.sv =====
// kvdc_color_cell: one entry of the color table; pulls its right neighbor when
// the table closes a gap. depends on kvdc_pkg

module kvdc_color_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  kvdc_pkg::color_cmd_t        cmd,
    input  logic                        shift_sel,
    input  logic                        alloc_sel,
    input  kvdc_pkg::color_entry_t      nb,
    output kvdc_pkg::color_entry_t      ent,
    output logic                        new_m,
    output logic                        old_m,
    output logic                        old_one
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [kvdc_pkg::COLOR_W-1:0]  value_reg;
    logic [kvdc_pkg::COLOR_W-1:0]  value_next;
    logic [kvdc_pkg::CNT_W-1:0]    count_reg;
    logic [kvdc_pkg::CNT_W-1:0]    count_next;
    logic                          new_m_reg;
    logic                          new_m_next;
    logic                          old_m_reg;
    logic                          old_m_next;
    logic                          old_one_reg;
    logic                          old_one_next;

    always_comb
    begin
        valid_next   = valid_reg;
        value_next   = value_reg;
        count_next   = count_reg;
        new_m_next   = new_m_reg;
        old_m_next   = old_m_reg;
        old_one_next = old_one_reg;
        if (cmd.cmp)
        begin
            new_m_next   = valid_reg && (value_reg == cmd.new_color);
            old_m_next   = valid_reg && (value_reg == cmd.prev_color);
            old_one_next = valid_reg && (value_reg == cmd.prev_color)
                           && (count_reg == kvdc_pkg::CNT_W'(1));
        end
        // gap close: this cell and all above the freed one take the neighbor
        if (shift_sel)
        begin
            valid_next = nb.valid;
            value_next = nb.value;
            count_next = nb.count;
        end
        else if (cmd.dec && old_m_reg)
        begin
            count_next = count_reg - kvdc_pkg::CNT_W'(1);
        end
        else if (cmd.inc && valid_reg && (value_reg == cmd.new_color))
        begin
            count_next = count_reg + kvdc_pkg::CNT_W'(1);
        end
        else if (alloc_sel)
        begin
            valid_next = 1'b1;
            value_next = cmd.new_color;
            count_next = kvdc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            new_m_reg   <= 1'b0;
            old_m_reg   <= 1'b0;
            old_one_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            new_m_reg   <= new_m_next;
            old_m_reg   <= old_m_next;
            old_one_reg <= old_one_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        count_reg <= count_next;
    end

    assign ent.valid = valid_reg;
    assign ent.value = value_reg;
    assign ent.count = count_reg;
    assign new_m     = new_m_reg;
    assign old_m     = old_m_reg;
    assign old_one   = old_one_reg;

endmodule

// ===== design/kvdc_key_row.sv =====
// kvdc_key_row: the row of key cells and a two-stage registered tree that
// returns hit and the key's current color. depends on kvdc_pkg, kvdc_key_cell

module kvdc_key_row
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  kvdc_pkg::key_cmd_t   cmd,
    output kvdc_pkg::key_res_t   res
);

    logic                          m_pad   [kvdc_pkg::KEY_PAD];
    logic [kvdc_pkg::COLOR_W-1:0]  col_pad [kvdc_pkg::KEY_PAD];
    logic                          grp_hit_reg [kvdc_pkg::KEY_NG];
    logic [kvdc_pkg::COLOR_W-1:0]  grp_col_reg [kvdc_pkg::KEY_NG];
    kvdc_pkg::key_res_t            res_reg;
    kvdc_pkg::key_res_t            res_next;

    for (genvar i = 0; i < kvdc_pkg::KEY_PAD; i++)
    begin : g_cell
        if (i < kvdc_pkg::KEY_ENTRIES)
        begin : g_real
            logic sel;
            assign sel = (cmd.fill == kvdc_pkg::KEY_CW'(i));
            kvdc_key_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .sel   (sel),
                .match (m_pad[i]),
                .color (col_pad[i])
            );
        end
        else
        begin : g_pad
            assign m_pad[i]   = 1'b0;
            assign col_pad[i] = '0;
        end
    end

    for (genvar g = 0; g < kvdc_pkg::KEY_NG; g++)
    begin : g_grp
        logic                          grp_hit_next;
        logic [kvdc_pkg::COLOR_W-1:0]  grp_col_next;

        always_comb
        begin
            grp_hit_next = 1'b0;
            grp_col_next = '0;
            for (int j = 0; j < kvdc_pkg::GRP; j++)
            begin
                grp_hit_next = grp_hit_next | m_pad[g*kvdc_pkg::GRP + j];
                if (m_pad[g*kvdc_pkg::GRP + j])
                begin
                    grp_col_next = grp_col_next | col_pad[g*kvdc_pkg::GRP + j];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            grp_hit_reg[g] <= grp_hit_next;
            grp_col_reg[g] <= grp_col_next;
        end
    end

    always_comb
    begin
        res_next = '0;
        for (int g = 0; g < kvdc_pkg::KEY_NG; g++)
        begin
            res_next.hit        = res_next.hit | grp_hit_reg[g];
            res_next.prev_color = res_next.prev_color | grp_col_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== design/kvdc_color_row.sv =====
// kvdc_color_row: the row of color cells kept packed from index zero, and a
// two-stage registered tree over their flags. depends on kvdc_pkg, kvdc_color_cell

module kvdc_color_row
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  kvdc_pkg::color_cmd_t   cmd,
    output kvdc_pkg::color_res_t   res
);

    kvdc_pkg::color_entry_t        ent [kvdc_pkg::COLOR_ENTRIES];
    logic                          new_pad [kvdc_pkg::COL_PAD];
    logic                          one_pad [kvdc_pkg::COL_PAD];
    logic [kvdc_pkg::COL_IW-1:0]   idx_pad [kvdc_pkg::COL_PAD];
    logic                          grp_new_reg [kvdc_pkg::COL_NG];
    logic                          grp_one_reg [kvdc_pkg::COL_NG];
    logic [kvdc_pkg::COL_IW-1:0]   grp_idx_reg [kvdc_pkg::COL_NG];
    kvdc_pkg::color_res_t          res_reg;
    kvdc_pkg::color_res_t          res_next;

    for (genvar i = 0; i < kvdc_pkg::COL_PAD; i++)
    begin : g_cell
        if (i < kvdc_pkg::COLOR_ENTRIES)
        begin : g_real
            logic                    shift_sel;
            logic                    alloc_sel;
            logic                    old_m;
            kvdc_pkg::color_entry_t  nb;

            assign shift_sel = cmd.shift && (kvdc_pkg::COL_IW'(i) >= cmd.old_idx);
            assign alloc_sel = cmd.alloc && (cmd.fill == kvdc_pkg::COL_CW'(i));
            if (i == kvdc_pkg::COLOR_ENTRIES - 1)
            begin : g_last
                assign nb = '0;
            end
            else
            begin : g_mid
                assign nb = ent[i+1];
            end

            kvdc_color_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .shift_sel (shift_sel),
                .alloc_sel (alloc_sel),
                .nb        (nb),
                .ent       (ent[i]),
                .new_m     (new_pad[i]),
                .old_m     (old_m),
                .old_one   (one_pad[i])
            );
            assign idx_pad[i] = old_m ? kvdc_pkg::COL_IW'(i) : '0;
        end
        else
        begin : g_pad
            assign new_pad[i] = 1'b0;
            assign one_pad[i] = 1'b0;
            assign idx_pad[i] = '0;
        end
    end

    for (genvar g = 0; g < kvdc_pkg::COL_NG; g++)
    begin : g_grp
        logic                          grp_new_next;
        logic                          grp_one_next;
        logic [kvdc_pkg::COL_IW-1:0]   grp_idx_next;

        always_comb
        begin
            grp_new_next = 1'b0;
            grp_one_next = 1'b0;
            grp_idx_next = '0;
            for (int j = 0; j < kvdc_pkg::GRP; j++)
            begin
                grp_new_next = grp_new_next | new_pad[g*kvdc_pkg::GRP + j];
                grp_one_next = grp_one_next | one_pad[g*kvdc_pkg::GRP + j];
                grp_idx_next = grp_idx_next | idx_pad[g*kvdc_pkg::GRP + j];
            end
        end

        always_ff @(posedge clk)
        begin
            grp_new_reg[g] <= grp_new_next;
            grp_one_reg[g] <= grp_one_next;
            grp_idx_reg[g] <= grp_idx_next;
        end
    end

    always_comb
    begin
        res_next = '0;
        for (int g = 0; g < kvdc_pkg::COL_NG; g++)
        begin
            res_next.new_found = res_next.new_found | grp_new_reg[g];
            res_next.old_one   = res_next.old_one | grp_one_reg[g];
            res_next.old_idx   = res_next.old_idx | grp_idx_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== design/keyed_value_distinct_counter.sv =====
// keyed_value_distinct_counter: top level, item sequencer and result register
// depends on kvdc_pkg, kvdc_key_row, kvdc_color_row
//
// Usage:
//   Input channel: in_valid / in_stall with ball_label and new_color. Each
//   transaction gives new_color to the key ball_label.
//   Output channel: out_valid / out_stall with distinct_colors and table_full,
//   exactly one transaction per input transaction, in order.
//   Sequence: the key lookup, then the color lookup, each a compare in every
//   cell followed by a two-stage registered reduction, then the separate
//   decrement and increment steps of the color row; an item dropped for a full
//   table changes nothing and skips the increment step. A new input is taken in
//   the cycle after the result is loaded, so the block takes no new item before
//   the last one is through; it waits to load while the output register is stalled.
//   Reset clears both tables, the counters and the output valid flag; no
//   clearing pass is needed.
//   A stalled result stays in the output register; the block still takes the
//   next input and holds its own result until the register is free.

module keyed_value_distinct_counter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [kvdc_pkg::LABEL_W-1:0]  ball_label,
    input  logic [kvdc_pkg::COLOR_W-1:0]  new_color,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [kvdc_pkg::OUT_W-1:0]    distinct_colors,
    output logic                          table_full
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_KCMP = 4'd1;
    localparam logic [3:0] S_KW1  = 4'd2;
    localparam logic [3:0] S_KW2  = 4'd3;
    localparam logic [3:0] S_CCMP = 4'd4;
    localparam logic [3:0] S_CW1  = 4'd5;
    localparam logic [3:0] S_CW2  = 4'd6;
    localparam logic [3:0] S_DEC  = 4'd7;
    localparam logic [3:0] S_INC  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]                    state_reg;
    logic [3:0]                    state_next;
    logic [kvdc_pkg::LABEL_W-1:0]  label_reg;
    logic [kvdc_pkg::LABEL_W-1:0]  label_next;
    logic [kvdc_pkg::COLOR_W-1:0]  color_reg;
    logic [kvdc_pkg::COLOR_W-1:0]  color_next;
    logic [kvdc_pkg::KEY_CW-1:0]   key_cnt_reg;
    logic [kvdc_pkg::KEY_CW-1:0]   key_cnt_next;
    logic [kvdc_pkg::COL_CW-1:0]   col_cnt_reg;
    logic [kvdc_pkg::COL_CW-1:0]   col_cnt_next;
    logic                          inc_reg;
    logic                          inc_next;
    logic                          alloc_reg;
    logic                          alloc_next;
    logic                          drop_reg;
    logic                          drop_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [kvdc_pkg::OUT_W-1:0]    dist_reg;
    logic [kvdc_pkg::OUT_W-1:0]    dist_next;
    logic                          tf_reg;
    logic                          tf_next;

    kvdc_pkg::key_cmd_t            key_cmd;
    kvdc_pkg::key_res_t            key_res;
    kvdc_pkg::color_cmd_t          col_cmd;
    kvdc_pkg::color_res_t          col_res;

    logic                          in_take;
    logic                          same;
    logic                          frees;
    logic                          key_full;
    logic                          col_full;
    logic                          drop;

    kvdc_key_row u_key_row
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (key_cmd),
        .res   (key_res)
    );

    kvdc_color_row u_color_row
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (col_cmd),
        .res   (col_res)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    // same color again leaves the tables untouched
    assign same     = key_res.hit && (key_res.prev_color == color_reg);
    assign frees    = key_res.hit && col_res.old_one && !same;
    assign key_full = (key_cnt_reg == kvdc_pkg::KEY_CW'(kvdc_pkg::KEY_ENTRIES));
    assign col_full = (col_cnt_reg == kvdc_pkg::COL_CW'(kvdc_pkg::COLOR_ENTRIES));
    assign drop     = (!key_res.hit && key_full)
                      || (!col_res.new_found && !frees && col_full);

    always_comb
    begin
        key_cmd        = '0;
        key_cmd.fill   = key_cnt_reg;
        key_cmd.label  = label_reg;
        key_cmd.color  = color_reg;
        key_cmd.cmp    = (state_reg == S_KCMP);

        col_cmd            = '0;
        col_cmd.fill       = col_cnt_reg;
        col_cmd.old_idx    = col_res.old_idx;
        col_cmd.new_color  = color_reg;
        col_cmd.prev_color = key_res.prev_color;
        col_cmd.cmp        = (state_reg == S_CCMP);

        state_next     = state_reg;
        label_next     = label_reg;
        color_next     = color_reg;
        key_cnt_next   = key_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        inc_next       = inc_reg;
        alloc_next     = alloc_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && out_stall;
        dist_next      = dist_reg;
        tf_next        = tf_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    label_next = ball_label;
                    color_next = new_color;
                    state_next = S_KCMP;
                end
            end
            S_KCMP: state_next = S_KW1;
            S_KW1:  state_next = S_KW2;
            S_KW2:  state_next = S_CCMP;
            S_CCMP: state_next = S_CW1;
            S_CW1:  state_next = S_CW2;
            S_CW2:  state_next = S_DEC;
            S_DEC:
            begin
                drop_next  = drop;
                inc_next   = !same;
                alloc_next = !col_res.new_found;
                if (drop)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    key_cmd.hit_wr = key_res.hit && !same;
                    key_cmd.alloc  = !key_res.hit;
                    if (!key_res.hit)
                    begin
                        key_cnt_next = key_cnt_reg + kvdc_pkg::KEY_CW'(1);
                    end
                    col_cmd.dec   = key_res.hit && !same;
                    col_cmd.shift = frees;
                    if (frees)
                    begin
                        col_cnt_next = col_cnt_reg - kvdc_pkg::COL_CW'(1);
                    end
                    state_next = S_INC;
                end
            end
            S_INC:
            begin
                col_cmd.inc   = inc_reg && !alloc_reg;
                col_cmd.alloc = inc_reg && alloc_reg;
                if (inc_reg && alloc_reg)
                begin
                    col_cnt_next = col_cnt_reg + kvdc_pkg::COL_CW'(1);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    tf_next        = drop_reg;
                    if (int'(col_cnt_reg) > kvdc_pkg::OUT_MAX)
                    begin
                        dist_next = kvdc_pkg::OUT_W'(kvdc_pkg::OUT_MAX);
                    end
                    else
                    begin
                        dist_next = kvdc_pkg::OUT_W'(col_cnt_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            inc_reg       <= 1'b0;
            alloc_reg     <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_cnt_reg   <= key_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            inc_reg       <= inc_next;
            alloc_reg     <= alloc_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        label_reg <= label_next;
        color_reg <= color_next;
        dist_reg  <= dist_next;
        tf_reg    <= tf_next;
    end

    assign out_valid       = out_valid_reg;
    assign distinct_colors = dist_reg;
    assign table_full      = tf_reg;

endmodule

// ===== dv/tb_keyed_value_distinct_counter.sv =====
// tb_keyed_value_distinct_counter: self-checking bench for the keyed distinct value counter
// predicts both tables and the distinct count in the bench; depends on kvdc_pkg and the DUT
`timescale 1ns / 1ps

module tb_keyed_value_distinct_counter;

    localparam int N_ITEMS     = 1750;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 20;

    typedef struct {
        logic [kvdc_pkg::LABEL_W-1:0] label;
        logic [kvdc_pkg::COLOR_W-1:0] color;
        bit                           drain;
    } assign_item_t;

    typedef struct {
        logic [kvdc_pkg::OUT_W-1:0] dc;
        logic                       full;
    } tally_t;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [kvdc_pkg::LABEL_W-1:0]   ball_label = '0;
    logic [kvdc_pkg::COLOR_W-1:0]   new_color = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [kvdc_pkg::OUT_W-1:0]     distinct_colors;
    logic                           table_full;

    assign_item_t                   pending[$];
    tally_t                         expected_tally[$];
    logic [kvdc_pkg::LABEL_W-1:0]   label_pool[$];
    int                             total_items;
    int                             sent_count;
    int                             mismatches;
    int                             cycles;

    // bench copy of the two tables
    bit                             key_used [kvdc_pkg::KEY_ENTRIES];
    logic [kvdc_pkg::LABEL_W-1:0]   key_lbl  [kvdc_pkg::KEY_ENTRIES];
    logic [kvdc_pkg::COLOR_W-1:0]   key_col  [kvdc_pkg::KEY_ENTRIES];
    bit                             col_used [kvdc_pkg::COLOR_ENTRIES];
    logic [kvdc_pkg::COLOR_W-1:0]   col_val  [kvdc_pkg::COLOR_ENTRIES];
    int                             col_cnt  [kvdc_pkg::COLOR_ENTRIES];
    int                             live_colors;

    keyed_value_distinct_counter DUT
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .ball_label      (ball_label),
        .new_color       (new_color),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .distinct_colors (distinct_colors),
        .table_full      (table_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int find_key(input logic [kvdc_pkg::LABEL_W-1:0] label);
        for (int i = 0; i < kvdc_pkg::KEY_ENTRIES; i++)
            if (key_used[i] && key_lbl[i] == label)
                return i;
        return -1;
    endfunction

    function automatic int free_key();
        for (int i = 0; i < kvdc_pkg::KEY_ENTRIES; i++)
            if (!key_used[i])
                return i;
        return -1;
    endfunction

    function automatic int find_color(input logic [kvdc_pkg::COLOR_W-1:0] color);
        for (int i = 0; i < kvdc_pkg::COLOR_ENTRIES; i++)
            if (col_used[i] && col_val[i] == color)
                return i;
        return -1;
    endfunction

    function automatic int free_color();
        for (int i = 0; i < kvdc_pkg::COLOR_ENTRIES; i++)
            if (!col_used[i])
                return i;
        return -1;
    endfunction

    function automatic logic [kvdc_pkg::OUT_W-1:0] shown_total();
        return (live_colors > kvdc_pkg::OUT_MAX) ? kvdc_pkg::OUT_W'(kvdc_pkg::OUT_MAX)
                                                 : kvdc_pkg::OUT_W'(live_colors);
    endfunction

    // one assignment against the bench tables; dropped items leave them untouched
    function automatic void apply_assignment(input logic [kvdc_pkg::LABEL_W-1:0] label,
                                             input logic [kvdc_pkg::COLOR_W-1:0] color,
                                             output tally_t res);
        int k;
        int old_slot;
        int new_slot;
        bit frees;
        k = find_key(label);
        old_slot = -1;
        frees = 1'b0;
        res.full = 1'b1;
        res.dc = shown_total();
        if (k < 0)
        begin
            k = free_key();
            if (k < 0)
                return;
        end
        else
        begin
            old_slot = find_color(key_col[k]);
            if (old_slot >= 0 && col_cnt[old_slot] <= 1 && key_col[k] != color)
                frees = 1'b1;
        end
        new_slot = find_color(color);
        if (new_slot < 0 && !frees && free_color() < 0)
            return;
        if (old_slot >= 0)
        begin
            if (col_cnt[old_slot] > 0)
                col_cnt[old_slot]--;
            if (col_cnt[old_slot] == 0)
            begin
                col_used[old_slot] = 1'b0;
                if (live_colors > 0)
                    live_colors--;
            end
        end
        key_used[k] = 1'b1;
        key_lbl[k] = label;
        key_col[k] = color;
        new_slot = find_color(color);
        if (new_slot < 0)
        begin
            new_slot = free_color();
            if (new_slot < 0)
            begin
                res.dc = shown_total();
                return;
            end
            col_used[new_slot] = 1'b1;
            col_val[new_slot] = color;
            col_cnt[new_slot] = 0;
            live_colors++;
        end
        col_cnt[new_slot]++;
        res.dc = shown_total();
        res.full = 1'b0;
    endfunction

    function automatic bit in_pool(input logic [kvdc_pkg::LABEL_W-1:0] label);
        foreach (label_pool[i])
            if (label_pool[i] == label)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [kvdc_pkg::LABEL_W-1:0] fresh_label();
        logic [kvdc_pkg::LABEL_W-1:0] cand;
        cand = $urandom();
        while (in_pool(cand))
            cand = $urandom();
        return cand;
    endfunction

    function automatic logic [kvdc_pkg::LABEL_W-1:0] pool_label();
        return label_pool[$urandom_range(label_pool.size() - 1)];
    endfunction

    // labels seen while the key table still has room are the ones that get a key
    task automatic queue_item(input logic [kvdc_pkg::LABEL_W-1:0] label,
                              input logic [kvdc_pkg::COLOR_W-1:0] color,
                              input bit drain);
        assign_item_t it;
        it.label = label;
        it.color = color;
        it.drain = drain;
        pending.push_back(it);
        if (!in_pool(label) && label_pool.size() < kvdc_pkg::KEY_ENTRIES)
            label_pool.push_back(label);
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    function automatic int tx_idle_pct();
        if (sent_count < total_items / 3)
            return 32;
        else if (sent_count < 2 * total_items / 3)
            return 76;
        return 0;
    endfunction

    function automatic int rx_idle_pct();
        if (sent_count < total_items / 3)
            return 76;
        else if (sent_count < 2 * total_items / 3)
            return 32;
        return 0;
    endfunction

    // driver: one item per transaction, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        logic   took;
        logic   go;
        tally_t pred;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            ball_label <= '0;
            new_color <= '0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                apply_assignment(ball_label, new_color, pred);
                expected_tally.push_back(pred);
                sent_count++;
            end
            if (!in_valid || took)
            begin
                go = 1'b0;
                if (pending.size() > 0 && $urandom_range(99) >= tx_idle_pct())
                    if (!pending[0].drain || expected_tally.size() == 0)
                        go = 1'b1;
                if (go)
                begin
                    in_valid <= 1'b1;
                    ball_label <= pending[0].label;
                    new_color <= pending[0].color;
                    pending.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transaction against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        tally_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tally.size() == 0)
                    flag_mismatch($sformatf("unexpected result distinct_colors=%0d table_full=%0b",
                                            distinct_colors, table_full));
                else
                begin
                    want = expected_tally.pop_front();
                    if (distinct_colors !== want.dc)
                        flag_mismatch($sformatf("distinct_colors got %0d want %0d",
                                                distinct_colors, want.dc));
                    if (table_full !== want.full)
                        flag_mismatch($sformatf("table_full got %0b want %0b",
                                                table_full, want.full));
                end
            end
            out_stall <= ($urandom_range(99) < rx_idle_pct());
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("keyed_value_distinct_counter verification failed");
            $finish;
        end
    end

    initial
    begin : run_test
        logic [kvdc_pkg::COLOR_W-1:0] hues[];
        logic [kvdc_pkg::LABEL_W-1:0] lbl;
        int                           n;
        int                           burst;

        // directed: extreme labels and colors, repeats, freeing and reuse of color entries
        queue_item(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_item(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_item(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        queue_item(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_item(32'h0000_0001, 32'h0000_0000, 1'b0);
        queue_item(32'h0000_0001, 32'h0000_0005, 1'b0);
        queue_item(32'hFFFF_FFFF, 32'h0000_0005, 1'b0);
        queue_item(32'h0000_0002, 32'h1234_5678, 1'b0);
        queue_item(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        queue_item(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        queue_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        queue_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        queue_item(32'h0000_0002, 32'h0000_0005, 1'b0);
        queue_item(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        queue_item(32'h0000_0000, 32'h0000_0005, 1'b0);
        queue_item(32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0);

        // small label pool over a small color set: counts go up and down often
        hues = new[8];
        hues[0] = 32'h0000_0000;
        hues[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            hues[i] = $urandom();
        for (int i = 0; i < 600; i++)
        begin
            if (label_pool.size() < 40 && $urandom_range(9) == 0)
                lbl = fresh_label();
            else
                lbl = pool_label();
            if ($urandom_range(99) < 70)
                queue_item(lbl, hues[$urandom_range(7)], (i == 0) || ($urandom_range(99) < 2));
            else
                queue_item(lbl, $urandom(), 1'b0);
        end

        // fill the key table, then throw new keys at it
        n = 0;
        while (label_pool.size() < kvdc_pkg::KEY_ENTRIES)
        begin
            queue_item(fresh_label(), $urandom(), n == 0);
            n++;
        end
        for (int i = 0; i < 60; i++)
        begin
            if ($urandom_range(99) < 40)
                queue_item(fresh_label(), $urandom(), 1'b0);
            else
                queue_item(pool_label(), hues[$urandom_range(3)], 1'b0);
        end

        // a distinct color on every key drives the count to its top
        foreach (label_pool[i])
            queue_item(label_pool[i], $urandom(), i == 0);
        queue_item(fresh_label(), $urandom(), 1'b1);

        // bursts over color sets from one value to more than the table holds
        while (pending.size() < N_ITEMS)
        begin
            case ($urandom_range(4))
                0: n = 1;
                1: n = 2;
                2: n = 16;
                3: n = 256;
                default: n = 300;
            endcase
            hues = new[n];
            foreach (hues[i])
                hues[i] = $urandom();
            if ($urandom_range(1))
                hues[0] = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'h0000_0000;
            burst = $urandom_range(20, 60);
            for (int i = 0; i < burst; i++)
            begin
                if ($urandom_range(9) == 0)
                    lbl = fresh_label();
                else
                    lbl = pool_label();
                queue_item(lbl, hues[$urandom_range(n - 1)], (i == 0) && ($urandom_range(2) == 0));
            end
        end
        total_items = pending.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() > 0 || in_valid || expected_tally.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0 && expected_tally.size() == 0)
            $display("keyed_value_distinct_counter verification clean");
        else
            $display("keyed_value_distinct_counter verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/kvdc_pkg.sv
design/kvdc_key_cell.sv
design/kvdc_color_cell.sv
design/kvdc_key_row.sv
design/kvdc_color_row.sv
design/keyed_value_distinct_counter.sv
dv/tb_keyed_value_distinct_counter.sv
